// ===== design/ttsp_pkg.sv =====
// Shared types, constants and saturation helpers for the token top-k sparse pooling block.
// Used by ttsp_mac, ttsp_div and token_topk_sparse_pooling; depends on nothing.
`default_nettype none
package ttsp_pkg;

    localparam int MAX_DIM   = 128;
    localparam int MAX_WIDTH = 64;
    localparam int DIM_W     = 7;
    localparam int COL_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 32;
    localparam int SCORE_W   = 40;
    localparam int SUM_W     = 46;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY = 2'd3;

    typedef struct packed {
        logic                      valid;
        logic [COL_W-1:0]          idx;
        logic signed [SCORE_W-1:0] score;
    } t_mac_res;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } t_div_res;

    function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v[SCORE_W] != v[SCORE_W-1]) begin
            r = v[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/ttsp_mac.sv =====
// Shared multiply-accumulate unit: one registered product, then a saturating add to a score.
// Depends on ttsp_pkg.
`default_nettype none
module ttsp_mac (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic [ttsp_pkg::COL_W-1:0]         i_idx,
    input  wire logic signed [ttsp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [ttsp_pkg::SAMPLE_W-1:0] i_coef,
    input  wire logic signed [ttsp_pkg::SCORE_W-1:0]  i_score,
    output ttsp_pkg::t_mac_res                      o_res
);
    import ttsp_pkg::*;

    logic                      r_vld;
    logic [COL_W-1:0]          r_idx;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SCORE_W-1:0] r_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_en;
        end
        r_idx   <= i_idx;
        r_prod  <= i_sample * i_coef;
        r_score <= i_score;
    end

    always_comb begin
        o_res.valid = r_vld;
        o_res.idx   = r_idx;
        o_res.score = sat_score($signed({r_score[SCORE_W-1], r_score})
                                + $signed({{(SCORE_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod}));
    end

endmodule
`default_nettype wire

// ===== design/ttsp_div.sv =====
// Restoring divider, one quotient bit per cycle: signed sum over an unsigned nonzero count,
// truncated toward zero. Depends on ttsp_pkg.
`default_nettype none
module ttsp_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [ttsp_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [ttsp_pkg::CNT_W-1:0]        i_divisor,
    output ttsp_pkg::t_div_res                     o_res
);
    import ttsp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [5:0]       r_cnt;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W:0]   r_rem;
    logic [CNT_W-1:0] r_den;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_sub;

    assign trial     = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(SUM_W - 1);
                r_neg  <= i_dividend[SUM_W-1];
                r_quo  <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial_sub;
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_comb begin
        o_res.done     = r_done;
        o_res.quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);
    end

endmodule
`default_nettype wire

// ===== design/token_topk_sparse_pooling.sv =====
// Top level of the token top-k sparse pooling block: sequencer, score, sum and coefficient
// stores, output register. Depends on ttsp_pkg, ttsp_mac and ttsp_div.
`default_nettype none
// A coefficient load item is written straight to the coefficient store. A token element item
// runs the single shared multiply-accumulate once per active column and then waits for the
// last write-back. The element that ends a token then ranks every score against every other
// through one read port of the score store. The element that ends a set then reads each
// column's sum and count, runs the bit-serial divider for each qualifying column in document
// mode, and waits while the output register is full before it passes a result on.
// The input side is ready only while the sequencer is idle. Results leave through a single
// output register, so the next set's items are taken while the last result still waits.
module token_topk_sparse_pooling (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0: coef_row[5:0], coef_col[12:6], sample[28:13], zero fill
    input  wire logic [31:0]                    s_axis_tdata,
    // tuser fields: operation
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata fields from bit 0: column[5:0], pooled_value[51:6], zero fill
    output logic [55:0]                         m_axis_tdata,
    // tuser fields: has_entry
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_we,
    input  wire logic [ttsp_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [ttsp_pkg::CFG_W-1:0]     i_cfg_data
);
    import ttsp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_RJ   = 4'd2;
    localparam logic [3:0] S_RJL  = 4'd3;
    localparam logic [3:0] S_RI   = 4'd4;
    localparam logic [3:0] S_KEEP = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_ER   = 4'd7;
    localparam logic [3:0] S_EC   = 4'd8;
    localparam logic [3:0] S_ED   = 4'd9;
    localparam logic [3:0] S_EP   = 4'd10;
    localparam logic [3:0] S_EF   = 4'd11;

    localparam logic OP_LOAD = 1'b0;

    // Configuration registers.
    logic [CFG_W-1:0] r_dim;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_topk;
    logic             r_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 8'd128;
            r_width <= 7'd64;
            r_topk  <= 7'd8;
            r_query <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIM:   r_dim   <= i_cfg_data;
                CFG_WIDTH: r_width <= i_cfg_data[DIM_W-1:0];
                CFG_TOPK:  r_topk  <= i_cfg_data[DIM_W-1:0];
                CFG_QUERY: r_query <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] dim_eff;
    logic [DIM_W-1:0] width_eff;
    assign dim_eff   = (r_dim == '0) ? 8'd1 : ((r_dim > 8'(MAX_DIM)) ? 8'(MAX_DIM) : r_dim);
    assign width_eff = (r_width == '0) ? 7'd1
                     : ((r_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : r_width);

    // Input field unpacking.
    logic                       in_acc;
    logic [COL_W-1:0]           in_row;
    logic [DIM_W-1:0]           in_col;
    logic signed [SAMPLE_W-1:0] in_sample;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_row    = s_axis_tdata[5:0];
    assign in_col    = s_axis_tdata[12:6];
    assign in_sample = s_axis_tdata[28:13];

    // Sequencer state.
    logic [3:0]                r_state;
    logic [DIM_W-1:0]          r_pos;
    logic [DIM_W-1:0]          r_w;
    logic [DIM_W-1:0]          r_k;
    logic                      r_last;
    logic                      r_fin;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [DIM_W-1:0]          r_j;
    logic [DIM_W-1:0]          r_i;
    logic [COL_W-1:0]          r_iq;
    logic                      r_rdv;
    logic [COL_W:0]            r_rank;
    logic signed [SCORE_W-1:0] r_sj;
    logic                      r_s1v;
    logic [COL_W-1:0]          r_s1j;
    logic                      r_pend;
    logic [COL_W-1:0]          r_pcol;
    logic signed [SUM_W-1:0]   r_pval;
    logic signed [SUM_W-1:0]   r_val;

    // Output register.
    logic                      r_ovld;
    logic [COL_W-1:0]          r_ocol;
    logic signed [SUM_W-1:0]   r_oval;
    logic                      r_ohas;
    logic                      r_olast;

    // Stores.
    logic signed [SAMPLE_W-1:0] r_coef_mem [MAX_WIDTH*MAX_DIM];
    logic signed [SAMPLE_W-1:0] r_coef_q;
    logic signed [SCORE_W-1:0]  r_score_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]       r_score_vld;
    logic signed [SCORE_W-1:0]  r_score_q;
    logic                       r_score_qv;
    logic signed [SUM_W-1:0]    r_sum_mem [MAX_WIDTH];
    logic [CNT_W-1:0]           r_cnt_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]       r_sum_vld;
    logic signed [SUM_W-1:0]    r_sum_q;
    logic [CNT_W-1:0]           r_cnt_q;
    logic                       r_sum_qv;

    logic [COL_W-1:0]          score_ra;
    logic signed [SCORE_W-1:0] score_rd;
    logic signed [SUM_W-1:0]   sum_rd;
    logic [CNT_W-1:0]          cnt_rd;
    logic                      load_we;
    logic                      sum_we;
    logic signed [SUM_W-1:0]   sum_wd;
    logic [CNT_W-1:0]          cnt_wd;
    logic                      qualifies;
    logic                      out_free;
    logic                      div_start;
    t_mac_res                  mac_res;
    t_div_res                  div_res;

    assign score_ra = (r_state == S_RI) ? r_i[COL_W-1:0] : r_j[COL_W-1:0];
    assign score_rd = r_score_qv ? r_score_q : '0;
    assign sum_rd   = r_sum_qv ? r_sum_q : '0;
    assign cnt_rd   = r_sum_qv ? r_cnt_q : '0;
    assign load_we  = in_acc && (s_axis_tuser == OP_LOAD);
    assign sum_we   = (r_state == S_ACC);
    assign sum_wd   = sat_sum($signed({sum_rd[SUM_W-1], sum_rd})
                              + $signed({{(SUM_W+1-SCORE_W){r_sj[SCORE_W-1]}}, r_sj}));
    assign cnt_wd   = ((r_sj != '0) && (cnt_rd < COUNT_MAX)) ? cnt_rd + 7'd1 : cnt_rd;
    assign qualifies = r_query ? (sum_rd != '0) : (cnt_rd != '0);
    assign out_free  = !r_ovld;
    assign div_start = (r_state == S_EC) && qualifies && !r_query;

    // Coefficient store: written by load items, read for the current element position.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_coef_mem[{in_row, in_col}] <= in_sample;
        end
        r_coef_q <= r_coef_mem[{r_j[COL_W-1:0], r_pos}];
    end

    // Score store, all entries reading as zero after a token finishes.
    always_ff @(posedge i_clk) begin
        if (mac_res.valid) begin
            r_score_mem[mac_res.idx] <= mac_res.score;
        end
        r_score_q <= r_score_mem[score_ra];
    end

    // Pooled sums and nonzero counts share one address and one valid bit per column.
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[r_j[COL_W-1:0]] <= sum_wd;
            r_cnt_mem[r_j[COL_W-1:0]] <= cnt_wd;
        end
        r_sum_q <= r_sum_mem[r_j[COL_W-1:0]];
        r_cnt_q <= r_cnt_mem[r_j[COL_W-1:0]];
    end

    ttsp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_s1v),
        .i_idx    (r_s1j),
        .i_sample (r_sample),
        .i_coef   (r_coef_q),
        .i_score  (score_rd),
        .o_res    (mac_res)
    );

    ttsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_rd),
        .i_divisor  (cnt_rd),
        .o_res      (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_s1v       <= 1'b0;
            r_rdv       <= 1'b0;
            r_pend      <= 1'b0;
            r_ovld      <= 1'b0;
            r_score_vld <= '0;
            r_score_qv  <= 1'b0;
            r_sum_vld   <= '0;
            r_sum_qv    <= 1'b0;
        end else begin
            r_score_qv <= r_score_vld[score_ra];
            r_sum_qv   <= r_sum_vld[r_j[COL_W-1:0]];
            if (mac_res.valid) begin
                r_score_vld[mac_res.idx] <= 1'b1;
            end
            if (sum_we) begin
                r_sum_vld[r_j[COL_W-1:0]] <= 1'b1;
            end
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (s_axis_tuser != OP_LOAD)) begin
                        r_sample <= in_sample;
                        r_last   <= s_axis_tlast;
                        r_w      <= width_eff;
                        r_k      <= (r_topk < width_eff) ? r_topk : width_eff;
                        r_fin    <= ({1'b0, r_pos} + 8'd1) >= dim_eff;
                        r_j      <= '0;
                        r_s1v    <= 1'b0;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    // Issue one column a cycle; each score is written back from the MAC's product register.
                    if (r_j < r_w) begin
                        r_s1v <= 1'b1;
                        r_s1j <= r_j[COL_W-1:0];
                        r_j   <= r_j + 7'd1;
                    end else begin
                        r_s1v <= 1'b0;
                        if (!r_s1v && !mac_res.valid) begin
                            r_j <= '0;
                            if (r_fin) begin
                                r_state <= S_RJ;
                            end else begin
                                r_pos   <= r_pos + 7'd1;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_RJ: begin
                    r_state <= S_RJL;
                end
                S_RJL: begin
                    r_sj    <= score_rd;
                    r_i     <= '0;
                    r_rank  <= '0;
                    r_rdv   <= 1'b0;
                    r_state <= S_RI;
                end
                S_RI: begin
                    // Sweep every score and count those ranked ahead of column j.
                    if (r_i < r_w) begin
                        r_rdv <= 1'b1;
                        r_iq  <= r_i[COL_W-1:0];
                        r_i   <= r_i + 7'd1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                    if (r_rdv && ((score_rd > r_sj)
                                  || ((score_rd == r_sj) && ({1'b0, r_iq} < r_j)))) begin
                        r_rank <= r_rank + 7'd1;
                    end
                    if ((r_i == r_w) && !r_rdv) begin
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: begin
                    if (r_rank < r_k) begin
                        r_state <= S_ACC;
                    end else if (r_j + 7'd1 == r_w) begin
                        r_score_vld <= '0;
                        r_pos       <= '0;
                        r_j         <= '0;
                        r_state     <= r_last ? S_ER : S_IDLE;
                    end else begin
                        r_j     <= r_j + 7'd1;
                        r_state <= S_RJ;
                    end
                end
                S_ACC: begin
                    if (r_j + 7'd1 == r_w) begin
                        r_score_vld <= '0;
                        r_pos       <= '0;
                        r_j         <= '0;
                        r_state     <= r_last ? S_ER : S_IDLE;
                    end else begin
                        r_j     <= r_j + 7'd1;
                        r_state <= S_RJ;
                    end
                end
                S_ER: begin
                    r_state <= (r_j < r_w) ? S_EC : S_EF;
                end
                S_EC: begin
                    r_val <= sum_rd;
                    if (!qualifies) begin
                        r_j     <= r_j + 7'd1;
                        r_state <= S_ER;
                    end else begin
                        r_state <= r_query ? S_EP : S_ED;
                    end
                end
                S_ED: begin
                    if (div_res.done) begin
                        r_val   <= div_res.quotient;
                        r_state <= S_EP;
                    end
                end
                S_EP: begin
                    // Hold one result back so that the final one can carry the last mark.
                    if (!r_pend || out_free) begin
                        if (r_pend) begin
                            r_ovld  <= 1'b1;
                            r_ocol  <= r_pcol;
                            r_oval  <= r_pval;
                            r_ohas  <= 1'b1;
                            r_olast <= 1'b0;
                        end
                        r_pend  <= 1'b1;
                        r_pcol  <= r_j[COL_W-1:0];
                        r_pval  <= r_val;
                        r_j     <= r_j + 7'd1;
                        r_state <= S_ER;
                    end
                end
                S_EF: begin
                    if (out_free) begin
                        r_ovld    <= 1'b1;
                        r_ocol    <= r_pend ? r_pcol : '0;
                        r_oval    <= r_pend ? r_pval : '0;
                        r_ohas    <= r_pend;
                        r_olast   <= 1'b1;
                        r_pend    <= 1'b0;
                        r_sum_vld <= '0;
                        r_j       <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {4'b0, r_oval, r_ocol};
    assign m_axis_tuser  = r_ohas;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEEP) |-> ({1'b0, r_rank} < {1'b0, r_w}))
        else $error("rank exceeds the active width");
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_ED))
        else $error("divider finished outside the divide step");
    a_acc_after_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_KEEP))
        else $error("sum update without a rank decision");
    a_no_mac_out_of_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_res.valid |-> (r_state == S_MAC))
        else $error("score write-back outside the accumulate phase");
`endif

endmodule
`default_nettype wire
